// ===== rtl/sha256_message_hasher_assert.svh =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher assertion macros
// Clocked checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH

// same-cycle implication
`define SHAMH_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shamh check failed");

// next-cycle implication
`define SHAMH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shamh check failed");

`endif

// ===== rtl/shamh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher package
// Shared types, round constants and initial hash values.
// ----------------------------------------------------------------------------
package shamh_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] chain_t;

	typedef struct packed {
		logic       put_en;
		logic [7:0] put_byte;
		logic       start;
		logic       init;
	} shamh_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_PAD80,
		ST_PADZ,
		ST_LEN,
		ST_OUT
	} shamh_state_t;

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [7:0] PAD_ZERO   = 8'h00;
	localparam logic [5:0] LEN_START  = 6'd56;
	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [2:0] LAST_WORD  = 3'd7;
	localparam logic [5:0] ROUND_LAST = 6'd63;

	localparam chain_t INIT_H = '{
		0: 32'h6a09e667, 1: 32'hbb67ae85, 2: 32'h3c6ef372, 3: 32'ha54ff53a,
		4: 32'h510e527f, 5: 32'h9b05688c, 6: 32'h1f83d9ab, 7: 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// ===== rtl/shamh_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Byte-wide block window plus one round unit reused for 64 rounds.
// ----------------------------------------------------------------------------
module shamh_core import shamh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  shamh_ctl_t ctl,
	output logic       done,
	output chain_t     chain
);

	chain_t     chain_q;
	chain_t     v_q;
	word_t      win_q [16];
	logic       run_q;
	logic       add_q;
	logic [5:0] round_q;

	word_t t1;
	word_t t2;
	word_t w_new;

	function automatic word_t rotr(word_t x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_sig0(word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sig1(word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t sml_sig0(word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sml_sig1(word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	always_comb begin
		t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ ROUND_K[round_q] + win_q[0];
		t2 = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = win_q[0] + sml_sig0(win_q[1]) + win_q[9] + sml_sig1(win_q[14]);
	end

	// window: win_q[0] is the oldest schedule word
	always_ff @(posedge clk) begin
		if (ctl.put_en) begin
			for (int j = 0; j < 15; j++) begin
				win_q[j] <= {win_q[j][23:0], win_q[j + 1][31:24]};
			end
			win_q[15] <= {win_q[15][23:0], ctl.put_byte};
		end else if (run_q) begin
			for (int j = 0; j < 15; j++) begin
				win_q[j] <= win_q[j + 1];
			end
			win_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			v_q <= chain_q;
		end else if (run_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= INIT_H;
			run_q   <= 1'b0;
			add_q   <= 1'b0;
			round_q <= '0;
		end else begin
			if (ctl.start) begin
				run_q   <= 1'b1;
				round_q <= '0;
			end else if (run_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == ROUND_LAST) begin
					run_q <= 1'b0;
					add_q <= 1'b1;
				end
			end
			if (add_q) begin
				add_q <= 1'b0;
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
			end else if (ctl.init) begin
				chain_q <= INIT_H;
			end
		end
	end

	assign done  = add_q;
	assign chain = chain_q;

endmodule

// ===== rtl/sha256_message_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-stream in, eight-word digest out, one round per cycle.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per byte; s_tuser flags a present byte, s_tlast
// ends the message (with or without a byte, so an empty message works).
// Output channel m_*: the digest as eight items, word 0 (most significant)
// first, m_tlast on the eighth.
// Throughput: a byte is taken every cycle until the 64th byte of a block;
// that block then runs 64 rounds on the shared round unit plus one add
// step, so s_tready is low until that add is done.
// On the end item the block pads one byte per cycle outside compression
// (0x80, zeros, eight length bytes, an idle ST_PADZ step before the length),
// compressing once or twice, then presents the digest. s_tready stays low
// until the last digest item is taken; a stalled receiver holds the digest.
// Reset (arst_n low) restores the initial hash values and empty counts; the
// same happens after every digest. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_assert.svh"

module sha256_message_hasher import shamh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] byte_present
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_number
	output logic        m_tlast    // final_word
);

	shamh_state_t state_q, state_d;
	shamh_state_t ret_q, ret_d;
	logic [5:0]   fill_q;
	logic [60:0]  msg_q;
	logic [2:0]   len_q;
	logic [2:0]   word_q;

	shamh_ctl_t ctl;
	logic       done;
	chain_t     chain;
	logic       blk_full;
	logic       in_acc;
	logic       out_acc;
	logic       out_end;
	logic [63:0] len_bits;
	logic [5:0]  len_sel;

	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;
	assign out_end  = out_acc && (word_q == LAST_WORD);
	assign blk_full = ctl.put_en && (fill_q == FILL_LAST);
	assign len_bits = {msg_q, 3'b000};
	assign len_sel  = {~len_q, 3'b000};

	shamh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.done   (done),
		.chain  (chain)
	);

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (blk_full) begin
						state_d = ST_HASH;
						ret_d   = s_tlast ? ST_PAD80 : ST_IDLE;
					end else if (s_tlast) begin
						state_d = ST_PAD80;
					end
				end
			end
			ST_HASH: begin
				if (done) begin
					state_d = ret_q;
				end
			end
			ST_PAD80: begin
				state_d = blk_full ? ST_HASH : ST_PADZ;
				ret_d   = ST_PADZ;
			end
			ST_PADZ: begin
				if (fill_q == LEN_START) begin
					state_d = ST_LEN;
				end else if (blk_full) begin
					state_d = ST_HASH;
					ret_d   = ST_PADZ;
				end
			end
			ST_LEN: begin
				if (len_q == LAST_WORD) begin
					state_d = ST_HASH;
					ret_d   = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctl.put_en   = 1'b0;
		ctl.put_byte = PAD_ZERO;
		ctl.init     = 1'b0;
		s_tready     = 1'b0;
		m_tvalid     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready     = 1'b1;
				ctl.put_en   = s_tvalid && s_tuser[0];
				ctl.put_byte = s_tdata;
			end
			ST_PAD80: begin
				ctl.put_en   = 1'b1;
				ctl.put_byte = PAD_MARK;
			end
			ST_PADZ: begin
				ctl.put_en = (fill_q != LEN_START);
			end
			ST_LEN: begin
				ctl.put_en   = 1'b1;
				ctl.put_byte = len_bits[len_sel +: 8];
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				ctl.init = out_end;
			end
			default: begin
			end
		endcase
		ctl.start = blk_full;
	end

	assign m_tdata = chain[word_q];
	assign m_tuser = word_q;
	assign m_tlast = (word_q == LAST_WORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			fill_q  <= '0;
			msg_q   <= '0;
			len_q   <= '0;
			word_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (ctl.put_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (in_acc && s_tuser[0]) begin
				msg_q <= msg_q + 61'd1;
			end
			if (state_q == ST_LEN) begin
				len_q <= len_q + 3'd1;
			end
			if (out_acc) begin
				word_q <= word_q + 3'd1;
			end
			if (out_end) begin
				fill_q <= '0;
				msg_q  <= '0;
				len_q  <= '0;
			end
		end
	end

	`SHAMH_ASSERT_NOW(a_one_side, s_tready, !m_tvalid)
	`SHAMH_ASSERT_NOW(a_done_hash, done, state_q == ST_HASH)
	`SHAMH_ASSERT_NOW(a_len_fill, state_q == ST_LEN, fill_q == {3'b111, len_q})
	`SHAMH_ASSERT_NEXT(a_clean_end, out_end, fill_q == 6'd0 && msg_q == 61'd0)
	`SHAMH_ASSERT_NOW(a_out_aligned, state_q == ST_OUT, fill_q == 6'd0)

endmodule

// ===== verif/sha256_message_hasher_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher checker
// Watches the byte and digest channels. From every accepted byte it keeps its
// own running SHA-256 state. On each end item it pads the message and queues
// the eight digest words. Each digest item taken from the block is then
// compared in order against the oldest queued word.
// ----------------------------------------------------------------------------
module sha256_message_hasher_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] byte_present
	input  logic        s_tlast,   // end_of_message
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] digest_word
	input  logic [2:0]  m_tuser,   // [2:0] word_number
	input  logic        m_tlast,   // final_word
	output int          err_count,
	output int          words_left,
	output int          words_seen,
	output int          spill_blocks
);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  pos;
		logic        last;
	} digest_item_t;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [7:0] ZERO_BYTE  = 8'h00;
	localparam int         LEN_OFFSET = 56;
	localparam int         BLOCK_LEN  = 64;

	localparam logic [31:0] RK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H0 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [31:0]  hash_state [8];
	logic [7:0]   block_buf [64];
	int unsigned  fill = 0;
	logic [60:0]  msg_len = '0;
	digest_item_t digest_q [$];
	int           errs = 0;
	int           seen = 0;
	int           spills = 0;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		for (i = 16; i < 64; i++)
			w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
		e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
		for (i = 0; i < 64; i++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ RK[i] + w[i];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
		hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
	endtask

	task automatic absorb(input logic [7:0] b);
		block_buf[fill] = b;
		fill++;
		if (fill == BLOCK_LEN) begin
			compress_block();
			fill = 0;
		end
	endtask

	task automatic restart_hash();
		int i;
		for (i = 0; i < 8; i++)
			hash_state[i] = H0[i];
		fill = 0;
		msg_len = '0;
	endtask

	task automatic finish_message();
		logic [63:0]  bit_len;
		digest_item_t item;
		int i;
		bit_len = {msg_len, 3'b000};
		// no room for marker plus length: one more block gets compressed
		if (fill >= LEN_OFFSET)
			spills++;
		absorb(PAD_BYTE);
		while (fill != LEN_OFFSET)
			absorb(ZERO_BYTE);
		for (i = 0; i < 8; i++)
			absorb(bit_len[63 - 8*i -: 8]);
		for (i = 0; i < 8; i++) begin
			item.word = hash_state[i];
			item.pos  = 3'(i);
			item.last = (i == 7);
			digest_q = {digest_q, item};
		end
		restart_hash();
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_item_t want;
		if (!arst_n) begin
			restart_hash();
			digest_q.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser[0]) begin
					absorb(s_tdata);
					msg_len = msg_len + 61'd1;
				end
				if (s_tlast)
					finish_message();
			end
			if (m_tvalid && m_tready) begin
				seen++;
				if (digest_q.size() == 0) begin
					errs++;
					$display("%0t: unexpected digest item: expected none, got word %h pos %0d last %b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want = digest_q.pop_front();
					if (m_tdata !== want.word || m_tuser !== want.pos || m_tlast !== want.last) begin
						errs++;
						$display("%0t: digest mismatch: expected word %h pos %0d last %b, got word %h pos %0d last %b",
							$time, want.word, want.pos, want.last, m_tdata, m_tuser, m_tlast);
					end
				end
			end
		end
		err_count    <= errs;
		words_left   <= digest_q.size();
		words_seen   <= seen;
		spill_blocks <= spills;
	end

endmodule

// ===== verif/sha256_message_hasher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Streams messages byte by byte into the hasher: empty and one-byte messages,
// lengths around the padding and block boundaries, end items with and without
// a byte, and ignored filler items. Both sides stall at random. The checker
// beside the block predicts and compares every digest item.
// ----------------------------------------------------------------------------
module sha256_message_hasher_test;

	localparam int LIMIT     = 200000;
	localparam int ITEM_GOAL = 110;
	localparam int MSG_GOAL  = 8;
	localparam int DRAIN     = 30;
	localparam int EDGE_LEN [6] = '{55, 56, 57, 63, 64, 120};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic [0:0]  s_tuser;   // [0] byte_present
	logic        s_tlast;   // end_of_message
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] digest_word
	logic [2:0]  m_tuser;   // [2:0] word_number
	logic        m_tlast;   // final_word

	int errors;
	int words_left;
	int words_seen;
	int spills;
	int items_sent = 0;
	int messages_sent = 0;
	int cycles = 0;
	bit send_steady = 1'b0;
	bit take_steady = 1'b0;

	sha256_message_hasher u_top (.*);

	sha256_message_hasher_check u_check (
		.*,
		.err_count(errors),
		.words_left(words_left),
		.words_seen(words_seen),
		.spill_blocks(spills)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int draw_wait(input bit steady);
		if (steady)
			return 0;
		return $urandom_range(12, 0);
	endfunction

	task automatic send_item(input logic [7:0] data, input logic present, input logic ends);
		int gap;
		if ($urandom_range(15, 0) == 0)
			send_steady = !send_steady;
		gap = draw_wait(send_steady);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= present;
		s_tlast  <= ends;
		do @(posedge clk); while (!s_tready);
		if (present || ends)
			items_sent++;
	endtask

	task automatic send_message(input int len, input bit carry);
		int i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(7, 0) == 0)
				send_item(8'($urandom_range(255, 0)), 1'b0, 1'b0);
			send_item(8'($urandom_range(255, 0)), 1'b1, carry && (i == len - 1));
		end
		if (!carry)
			send_item(8'($urandom_range(255, 0)), 1'b0, 1'b1);
		messages_sent++;
	endtask

	// digest receiver
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(15, 0) == 0)
				take_steady = !take_steady;
			gap = draw_wait(take_steady);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		int len;
		bit carry;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		s_tlast  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// filler, empty message, one-byte messages, byte extremes
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h5a, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'ha5, 1'b0, 1'b1);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h7f, 1'b1, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		messages_sent += 5;

		// random messages, a third of them near the padding/block edges
		while (items_sent < ITEM_GOAL || messages_sent < MSG_GOAL) begin
			if ($urandom_range(2, 0) == 0)
				len = EDGE_LEN[$urandom_range(5, 0)];
			else
				len = $urandom_range(24, 0);
			// keep the total close to the item budget
			if (items_sent >= ITEM_GOAL)
				len = 0;
			else if (len > ITEM_GOAL - items_sent)
				len = ITEM_GOAL - items_sent;
			if (len == 0)
				carry = 1'b0;
			else if (len % 64 == 0)
				carry = 1'b1;
			else
				carry = $urandom_range(1, 0);
			send_message(len, carry);
		end
		send_item(8'($urandom_range(255, 0)), 1'b0, 1'b0);
		s_tvalid <= 1'b0;

		do @(posedge clk); while (words_left != 0);
		repeat (DRAIN) @(posedge clk);

		$display("Covered %0d byte/end items in %0d messages; %0d digest words compared.",
			items_sent, messages_sent, words_seen);
		$display("%0d messages needed an extra padding block.", spills);
		if (errors == 0 && words_left == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
